@@ rtl/bmp_pkg.sv @@
// ============================================================================
// bmp_pkg
// Shared constants for the binomial coefficient block: the prime modulus,
// the Barrett reduction constant and the latency of the modular multiplier.
// ============================================================================
package bmp_pkg;

    localparam int VAL_W = 30;
    localparam int ARG_W = 16;

    // The prime modulus and the Fermat exponent used to find the inverse.
    localparam logic [VAL_W-1:0] PRIME    = 30'd1000000007;
    localparam logic [VAL_W-1:0] FERMAT_E = 30'd1000000005;

    // Barrett constant floor(2^60 / PRIME), which fits in 31 bits.
    localparam logic [30:0] BARRETT_MU = 31'((64'd1 << 60) / 64'd1000000007);

    // Cycles from operands to result in the modular multiplier.
    localparam int MUL_LAT = 4;

endpackage

@@ rtl/bmp_channels.sv @@
// ============================================================================
// bmp channels
// Valid/ready channel interfaces for query beats and result beats.
// ============================================================================
interface bmp_query_if;
    logic                                valid;
    logic                                ready;
    logic signed [bmp_pkg::ARG_W-1:0]    query_n;
    logic signed [bmp_pkg::ARG_W-1:0]    query_r;

    modport source (output valid, output query_n, output query_r, input ready);
    modport sink   (input valid, input query_n, input query_r, output ready);
endinterface

interface bmp_result_if;
    logic                          valid;
    logic                          ready;
    logic [bmp_pkg::VAL_W-1:0]     binomial_value;
    logic                          out_of_range;

    modport source (output valid, output binomial_value, output out_of_range, input ready);
    modport sink   (input valid, input binomial_value, input out_of_range, output ready);
endinterface

@@ rtl/bmp_mulmod.sv @@
// ============================================================================
// bmp_mulmod
// Four-stage pipelined multiplier modulo the prime, using Barrett reduction.
// ============================================================================
module bmp_mulmod
(
    input  logic                        clk,
    input  logic                        en,
    input  logic [bmp_pkg::VAL_W-1:0]   a,
    input  logic [bmp_pkg::VAL_W-1:0]   b,
    output logic [bmp_pkg::VAL_W-1:0]   r
);

    logic [59:0] prod_reg;
    logic [30:0] quot_reg;
    logic [31:0] xlo2_reg;
    logic [31:0] qp_reg;
    logic [31:0] xlo3_reg;
    logic [29:0] r_reg;

    logic [61:0] est;
    logic [60:0] qp_full;
    logic [31:0] diff;
    logic [31:0] p1;
    logic [31:0] p2;

    assign est     = 62'(prod_reg[59:29]) * 62'(bmp_pkg::BARRETT_MU);
    assign qp_full = 61'(quot_reg) * 61'(bmp_pkg::PRIME);
    assign diff    = xlo3_reg - qp_reg;
    assign p1      = 32'(bmp_pkg::PRIME);
    assign p2      = 32'(bmp_pkg::PRIME) << 1;

    // The quotient estimate falls short by at most two, so the remainder
    // stays below three times the prime and two compares finish it.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 60'(a) * 60'(b);
            quot_reg <= est[61:31];
            xlo2_reg <= prod_reg[31:0];
            qp_reg   <= qp_full[31:0];
            xlo3_reg <= xlo2_reg;
            if (diff >= p2)
            begin
                r_reg <= 30'(diff - p2);
            end
            else if (diff >= p1)
            begin
                r_reg <= 30'(diff - p1);
            end
            else
            begin
                r_reg <= diff[29:0];
            end
        end
    end

    assign r = r_reg;

endmodule

@@ rtl/binomial_mod_prime.sv @@
// ============================================================================
// binomial_mod_prime
// Binomial coefficients modulo 1000000007 from factorial and inverse
// factorial tables that the block builds in its own memories after reset.
// ============================================================================
//
//  Channel   Dir   Payload                          Beat accepted when
//  query     in    query_n[15:0], query_r[15:0]     query.valid && query.ready
//  result    out   binomial_value[29:0], out_of_range  result.valid && result.ready
//
// After reset the build sequencer fills both tables: each table entry and
// each square-and-multiply step waits the full latency of the shared
// modular multiplier, so the multiplier loop sets the build time.
// Queries are refused until both tables are built; then one query beat is
// taken every cycle while the skid register is empty.
// The three table reads and two chained modular multipliers form a
// pipeline that advances as a whole; a skid register behind the output
// register lets one more beat finish while the result side stalls.
//
module binomial_mod_prime
#(
    parameter int MAX_N = 4096
)
(
    input  logic            clk,
    input  logic            rst_n,
    bmp_query_if.sink       query,
    bmp_result_if.source    result
);

    localparam int DEPTH = MAX_N + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int LAT   = bmp_pkg::MUL_LAT;
    localparam int PIPE  = 2 * LAT + 1;
    localparam logic [4:0] LAST_BIT = 5'(bmp_pkg::VAL_W - 1);
    localparam logic [AW-1:0] TOP_IDX = AW'(MAX_N);

    typedef enum logic [2:0]
    {
        ST_INIT,
        ST_FACT,
        ST_POW_ACC,
        ST_POW_BASE,
        ST_IFACT,
        ST_DONE
    } seq_state_t;

    // ------------------------------------------------------------------
    // Table memories: one write port each; the inverse table has two
    // read ports since a query needs both inverse factorials.
    // ------------------------------------------------------------------
    logic [29:0] fact_mem  [DEPTH];
    logic [29:0] ifact_mem [DEPTH];

    seq_state_t  state_reg;
    logic [2:0]  cnt_reg;
    logic [AW-1:0] idx_reg;
    logic [4:0]  bit_reg;
    logic [29:0] op_a_reg;
    logic [29:0] op_b_reg;
    logic [29:0] acc_reg;
    logic [29:0] base_reg;
    logic        tables_ready_reg;

    logic          res_ok;
    logic          fact_we;
    logic [AW-1:0] fact_waddr;
    logic [29:0]   fact_wdata;
    logic          ifact_we;
    logic [AW-1:0] ifact_waddr;
    logic [29:0]   ifact_wdata;

    logic [29:0] mul_a_r;
    logic [29:0] mul_b_r;
    logic [29:0] mul_a_in_a;
    logic [29:0] mul_a_in_b;

    // Query pipeline.
    logic        adv;
    logic        q_fire;
    logic signed [31:0] n_s;
    logic signed [31:0] r_s;
    logic signed [31:0] d_s;
    logic        q_oor;
    logic        q_kill;
    logic [AW-1:0] rd_n;
    logic [AW-1:0] rd_r;
    logic [AW-1:0] rd_d;
    logic [29:0] rd_fact_reg;
    logic [29:0] rd_ir_reg;
    logic [29:0] rd_id_reg;
    logic [29:0] id_dly_reg [LAT];
    logic [PIPE-1:0] vld_reg;
    logic [PIPE-1:0] kill_reg;
    logic [PIPE-1:0] oor_reg;
    logic [29:0] pipe_value;

    // Output register and skid register.
    logic        out_valid_reg;
    logic [29:0] out_value_reg;
    logic        out_oor_reg;
    logic        skid_valid_reg;
    logic [29:0] skid_value_reg;
    logic        skid_oor_reg;

    // ------------------------------------------------------------------
    // Build sequencer. Operands are held steady while the multiplier
    // works; the count reaching zero marks a settled result.
    // ------------------------------------------------------------------
    assign res_ok = (cnt_reg == 3'd0);

    always_comb
    begin
        fact_we     = 1'b0;
        fact_waddr  = idx_reg;
        fact_wdata  = mul_a_r;
        ifact_we    = 1'b0;
        ifact_waddr = idx_reg - AW'(1);
        ifact_wdata = mul_a_r;
        case (state_reg)
            ST_INIT:
            begin
                fact_we    = 1'b1;
                fact_waddr = '0;
                fact_wdata = 30'd1;
            end
            ST_FACT:
            begin
                fact_we = res_ok;
            end
            ST_POW_BASE:
            begin
                ifact_we    = res_ok && (bit_reg == LAST_BIT);
                ifact_waddr = TOP_IDX;
                ifact_wdata = acc_reg;
            end
            ST_IFACT:
            begin
                ifact_we = res_ok;
            end
            default:
            begin
                fact_we  = 1'b0;
                ifact_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_INIT;
            cnt_reg          <= 3'(LAT);
            idx_reg          <= '0;
            bit_reg          <= '0;
            op_a_reg         <= '0;
            op_b_reg         <= '0;
            acc_reg          <= '0;
            base_reg         <= '0;
            tables_ready_reg <= 1'b0;
        end
        else
        begin
            if (!res_ok && (state_reg != ST_INIT))
            begin
                cnt_reg <= cnt_reg - 3'd1;
            end
            case (state_reg)
                ST_INIT:
                begin
                    op_a_reg  <= 30'd1;
                    op_b_reg  <= 30'd1;
                    idx_reg   <= AW'(1);
                    cnt_reg   <= 3'(LAT);
                    state_reg <= ST_FACT;
                end
                ST_FACT:
                begin
                    if (res_ok)
                    begin
                        cnt_reg <= 3'(LAT);
                        if (idx_reg == TOP_IDX)
                        begin
                            base_reg  <= mul_a_r;
                            acc_reg   <= 30'd1;
                            op_a_reg  <= 30'd1;
                            op_b_reg  <= mul_a_r;
                            bit_reg   <= '0;
                            state_reg <= ST_POW_ACC;
                        end
                        else
                        begin
                            op_a_reg <= mul_a_r;
                            op_b_reg <= 30'(idx_reg + AW'(1));
                            idx_reg  <= idx_reg + AW'(1);
                        end
                    end
                end
                ST_POW_ACC:
                begin
                    if (res_ok)
                    begin
                        if (bmp_pkg::FERMAT_E[bit_reg])
                        begin
                            acc_reg <= mul_a_r;
                        end
                        op_a_reg  <= base_reg;
                        op_b_reg  <= base_reg;
                        cnt_reg   <= 3'(LAT);
                        state_reg <= ST_POW_BASE;
                    end
                end
                ST_POW_BASE:
                begin
                    if (res_ok)
                    begin
                        base_reg <= mul_a_r;
                        op_a_reg <= acc_reg;
                        cnt_reg  <= 3'(LAT);
                        if (bit_reg == LAST_BIT)
                        begin
                            op_b_reg  <= 30'(MAX_N);
                            idx_reg   <= TOP_IDX;
                            state_reg <= ST_IFACT;
                        end
                        else
                        begin
                            op_b_reg  <= mul_a_r;
                            bit_reg   <= bit_reg + 5'd1;
                            state_reg <= ST_POW_ACC;
                        end
                    end
                end
                ST_IFACT:
                begin
                    if (res_ok)
                    begin
                        op_a_reg <= mul_a_r;
                        cnt_reg  <= 3'(LAT);
                        if (idx_reg == AW'(1))
                        begin
                            tables_ready_reg <= 1'b1;
                            state_reg        <= ST_DONE;
                        end
                        else
                        begin
                            op_b_reg <= 30'(idx_reg - AW'(1));
                            idx_reg  <= idx_reg - AW'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_DONE;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Query decode. Invalid queries read entry zero and are zeroed at the
    // end of the pipeline.
    // ------------------------------------------------------------------
    assign adv          = !skid_valid_reg;
    assign query.ready  = tables_ready_reg && !skid_valid_reg;
    assign q_fire       = query.valid && query.ready;

    assign n_s    = 32'(query.query_n);
    assign r_s    = 32'(query.query_r);
    assign d_s    = n_s - r_s;
    assign q_oor  = (n_s > MAX_N);
    assign q_kill = q_oor || (n_s < 0) || (r_s < 0) || (n_s < r_s);
    assign rd_n   = q_kill ? '0 : n_s[AW-1:0];
    assign rd_r   = q_kill ? '0 : r_s[AW-1:0];
    assign rd_d   = q_kill ? '0 : d_s[AW-1:0];

    always_ff @(posedge clk)
    begin
        if (fact_we)
        begin
            fact_mem[fact_waddr] <= fact_wdata;
        end
        if (adv)
        begin
            rd_fact_reg <= fact_mem[rd_n];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ifact_we)
        begin
            ifact_mem[ifact_waddr] <= ifact_wdata;
        end
        if (adv)
        begin
            rd_ir_reg <= ifact_mem[rd_r];
            rd_id_reg <= ifact_mem[rd_d];
        end
    end

    // The second inverse factorial waits for the first product.
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            id_dly_reg[0] <= rd_id_reg;
            for (int k = 1; k < LAT; k++)
            begin
                id_dly_reg[k] <= id_dly_reg[k-1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            kill_reg <= '0;
            oor_reg  <= '0;
        end
        else if (adv)
        begin
            vld_reg  <= {vld_reg[PIPE-2:0], q_fire};
            kill_reg <= {kill_reg[PIPE-2:0], q_kill};
            oor_reg  <= {oor_reg[PIPE-2:0], q_oor};
        end
    end

    // The first multiplier serves the build sequencer until the tables are
    // ready and the queries afterward.
    assign mul_a_in_a = tables_ready_reg ? rd_fact_reg : op_a_reg;
    assign mul_a_in_b = tables_ready_reg ? rd_ir_reg   : op_b_reg;

    bmp_mulmod u_mul_a
    (
        .clk (clk),
        .en  (adv),
        .a   (mul_a_in_a),
        .b   (mul_a_in_b),
        .r   (mul_a_r)
    );

    bmp_mulmod u_mul_b
    (
        .clk (clk),
        .en  (adv),
        .a   (mul_a_r),
        .b   (id_dly_reg[LAT-1]),
        .r   (mul_b_r)
    );

    assign pipe_value = kill_reg[PIPE-1] ? '0 : mul_b_r;

    // ------------------------------------------------------------------
    // Output register with a skid register behind it. While the skid is
    // empty the pipeline advances and its last beat always has a place.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_valid_reg  <= 1'b1;
                skid_valid_reg <= 1'b0;
            end
            else
            begin
                out_valid_reg <= vld_reg[PIPE-1];
            end
        end
        else if (adv && vld_reg[PIPE-1])
        begin
            skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_valid_reg || result.ready)
        begin
            if (skid_valid_reg)
            begin
                out_value_reg <= skid_value_reg;
                out_oor_reg   <= skid_oor_reg;
            end
            else
            begin
                out_value_reg <= pipe_value;
                out_oor_reg   <= oor_reg[PIPE-1];
            end
        end
        else if (adv)
        begin
            skid_value_reg <= pipe_value;
            skid_oor_reg   <= oor_reg[PIPE-1];
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.binomial_value = out_value_reg;
    assign result.out_of_range   = out_oor_reg;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_no_query_before_ready: assert property (@(posedge clk) disable iff (!rst_n)
        q_fire |-> tables_ready_reg)
        else $error("query beat accepted before the tables were built");

    a_ready_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        tables_ready_reg |=> tables_ready_reg)
        else $error("tables ready flag dropped");

    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid register holds a beat while the output register is empty");

    a_oor_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.out_of_range) |-> (result.binomial_value == '0))
        else $error("out of range result carries a nonzero value");

    a_value_reduced: assert property (@(posedge clk) disable iff (!rst_n)
        result.valid |-> (result.binomial_value < bmp_pkg::PRIME))
        else $error("result value not reduced modulo the prime");

endmodule
